FILE: sv/bounded_integer_set_core_defines.svh
// ----------------------------------------------------------------------------
// Bounded integer set assertion macros
// Shared macros for the concurrent checks on the set core ports.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_INTEGER_SET_CORE_DEFINES_SVH
`define BOUNDED_INTEGER_SET_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define BIS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define BIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/bis_pkg.sv
// ----------------------------------------------------------------------------
// Bounded integer set package
// Widths, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int ELEM_W       = 32;
  localparam int MODE_W       = 2;
  localparam int SIZE_W       = 7;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  typedef struct packed {
    logic clr_en;
    logic load;
    logic scan_en;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic idx_done;
  } status_t;

endpackage

FILE: sv/bounded_integer_set_core.sv
// ----------------------------------------------------------------------------
// Bounded integer set core
// Insert, remove and membership test on a table of distinct 32-bit values.
// ----------------------------------------------------------------------------
// The table sits in a memory with one write port and one registered read
// port that is swept one entry per cycle to find a match and the lowest free
// slot. The last compare settles before a commit step writes the entry and
// the count; the commit waits while an earlier result is still unread. A new
// word is accepted only once the previous one has committed. After reset the
// core clears the table's valid marks in a pass with in_ready low. A finished
// result waits in the output register while the next word is accepted.
module bounded_integer_set_core #(
  parameter int CAPACITY = bis_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bis_pkg::MODE_W-1:0]        in_mode,
  input  logic signed [bis_pkg::ELEM_W-1:0] in_element,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_success,
  output logic                              out_table_full,
  output logic [bis_pkg::SIZE_W-1:0]        out_set_size
);

  bis_pkg::cmd_t    cmd;
  bis_pkg::status_t status;

  bis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bis_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_mode        (in_mode),
    .in_element     (in_element),
    .out_success    (out_success),
    .out_table_full (out_table_full),
    .out_set_size   (out_set_size)
  );

endmodule

FILE: sv/bis_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded integer set controller
// Sequences the clearing pass, the table sweep and the result handoff.
// ----------------------------------------------------------------------------
module bis_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  bis_pkg::status_t status,
  output bis_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        if (status.idx_done) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.clr_en = 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.idx_done) begin
          state_nxt = ST_COMMIT;
        end else begin
          cmd.scan_en = 1'b1;
        end
      end
      ST_COMMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign out_valid_nxt = cmd.commit | (out_valid_r & ~out_ready);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: sv/bis_dpath.sv
// ----------------------------------------------------------------------------
// Bounded integer set datapath
// Entry table, sweep counter, match and free-slot search, count and result.
// ----------------------------------------------------------------------------
module bis_dpath #(
  parameter int CAPACITY = bis_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bis_pkg::cmd_t                     cmd,
  output bis_pkg::status_t                  status,
  input  logic [bis_pkg::MODE_W-1:0]        in_mode,
  input  logic signed [bis_pkg::ELEM_W-1:0] in_element,
  output logic                              out_success,
  output logic                              out_table_full,
  output logic [bis_pkg::SIZE_W-1:0]        out_set_size
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = bis_pkg::ELEM_W + 1;

  logic [DW-1:0]                  mem_r [CAPACITY];
  logic [DW-1:0]                  rd_data_r;
  logic [AW:0]                    idx_r, idx_nxt;
  logic                           cmp_vld_r;
  logic [AW-1:0]                  cmp_idx_r;
  logic                           found_r, found_nxt;
  logic [AW-1:0]                  found_idx_r, found_idx_nxt;
  logic                           free_r, free_nxt;
  logic [AW-1:0]                  free_idx_r, free_idx_nxt;
  logic [bis_pkg::MODE_W-1:0]     mode_r;
  logic [bis_pkg::ELEM_W-1:0]     elem_r;
  logic [CW-1:0]                  count_r, count_nxt;
  logic                           ok, full;
  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;
  logic [DW-1:0]                  wr_data;
  logic                           op_wr;
  logic [AW-1:0]                  op_addr;
  logic                           op_valid;
  logic                           success_r, table_full_r;
  logic [bis_pkg::SIZE_W-1:0]     set_size_r;

  assign status.idx_done = (idx_r == (AW+1)'(CAPACITY));

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.clr_en || cmd.scan_en) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_comb begin
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    if (cmd.load) begin
      found_nxt = 1'b0;
      free_nxt  = 1'b0;
    end else if (cmp_vld_r) begin
      if (rd_data_r[DW-1] && (rd_data_r[DW-2:0] == elem_r) && !found_r) begin
        found_nxt     = 1'b1;
        found_idx_nxt = cmp_idx_r;
      end
      if (!rd_data_r[DW-1] && !free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = cmp_idx_r;
      end
    end
  end

  always_comb begin
    ok        = 1'b0;
    full      = 1'b0;
    op_wr     = 1'b0;
    op_addr   = found_idx_r;
    op_valid  = 1'b0;
    count_nxt = count_r;
    unique case (mode_r)
      bis_pkg::MODE_INSERT: begin
        if (!found_r) begin
          if (free_r) begin
            ok        = 1'b1;
            op_wr     = 1'b1;
            op_addr   = free_idx_r;
            op_valid  = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            full = 1'b1;
          end
        end
      end
      bis_pkg::MODE_REMOVE: begin
        if (found_r) begin
          ok    = 1'b1;
          op_wr = 1'b1;
          if (count_r != '0) begin
            count_nxt = count_r - 1'b1;
          end
        end
      end
      bis_pkg::MODE_QUERY: begin
        ok = found_r;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r[AW-1:0];
    wr_data = '0;
    if (cmd.clr_en) begin
      wr_en = 1'b1;
    end else if (cmd.commit && op_wr) begin
      wr_en   = 1'b1;
      wr_addr = op_addr;
      wr_data = {op_valid, elem_r};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
      free_r    <= 1'b0;
      count_r   <= '0;
    end else begin
      idx_r     <= idx_nxt;
      cmp_vld_r <= cmd.scan_en;
      found_r   <= found_nxt;
      free_r    <= free_nxt;
      if (cmd.commit) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r   <= idx_r[AW-1:0];
    found_idx_r <= found_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    if (cmd.load) begin
      mode_r <= in_mode;
      elem_r <= in_element;
    end
    if (cmd.commit) begin
      success_r    <= ok;
      table_full_r <= full;
      set_size_r   <= bis_pkg::SIZE_W'(count_nxt);
    end
  end

  assign out_success    = success_r;
  assign out_table_full = table_full_r;
  assign out_set_size   = set_size_r;

endmodule

FILE: sv/bis_checker.sv
// ----------------------------------------------------------------------------
// Bounded integer set port checker
// Port-level checks on result coding, count range and word handoff.
// ----------------------------------------------------------------------------
`include "bounded_integer_set_core_defines.svh"

module bis_checker #(
  parameter int CAPACITY = bis_pkg::CAPACITY_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [bis_pkg::MODE_W-1:0]        in_mode,
  input logic signed [bis_pkg::ELEM_W-1:0] in_element,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_success,
  input logic                              out_table_full,
  input logic [bis_pkg::SIZE_W-1:0]        out_set_size
);

  `BIS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_set_size),
                   "result word dropped or changed while stalled")
  `BIS_ASSERT_SAME(a_full_not_ok, out_valid, !(out_success && out_table_full),
                   "full flag raised on a successful word")
  `BIS_ASSERT_SAME(a_size_range, out_valid,
                   (CAPACITY > 127) || (out_set_size <= CAPACITY),
                   "set size beyond capacity")
  `BIS_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready,
                   "second word accepted during a sweep")
  `BIS_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
                   in_valid && $stable(in_mode) && $stable(in_element),
                   "input word changed while waiting")

endmodule

bind bounded_integer_set_core bis_checker #(
  .CAPACITY (CAPACITY)
) u_bis_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_mode        (in_mode),
  .in_element     (in_element),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_success    (out_success),
  .out_table_full (out_table_full),
  .out_set_size   (out_set_size)
);

FILE: bench/bounded_integer_set_core_test.sv
// ----------------------------------------------------------------------------
// Bounded integer set core testbench
// Drives insert, remove, membership and unused-mode words into the set core
// with random idling on both channels. A shadow copy of the table predicts
// each result, and every result word is compared field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic                       success;
  logic                       table_full;
  logic [bis_pkg::SIZE_W-1:0] set_size;
} set_reply_t;

class set_shadow;
  localparam int SLOTS = bis_pkg::CAPACITY_DEF;

  logic [bis_pkg::ELEM_W-1:0] slot_value [SLOTS];
  bit                         slot_used  [SLOTS];
  int unsigned                member_count;
  set_reply_t                 pending_replies [$];
  int unsigned                mismatches;

  function new();
    foreach (slot_used[i]) begin
      slot_used[i]  = 1'b0;
      slot_value[i] = '0;
    end
    member_count = 0;
    mismatches   = 0;
  endfunction

  function int unsigned outstanding();
    return pending_replies.size();
  endfunction

  function void note_request(logic [bis_pkg::MODE_W-1:0] mode,
                             logic [bis_pkg::ELEM_W-1:0] elem);
    int         hit;
    int         gap;
    int         i;
    set_reply_t r;
    hit = -1;
    gap = -1;
    r   = '0;
    for (i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_value[i] == elem && hit < 0) hit = i;
      if (!slot_used[i] && gap < 0) gap = i;
    end
    case (mode)
      bis_pkg::MODE_INSERT: begin
        if (hit < 0) begin
          if (gap < 0) begin
            r.table_full = 1'b1;
          end else begin
            slot_value[gap] = elem;
            slot_used[gap]  = 1'b1;
            member_count++;
            r.success = 1'b1;
          end
        end
      end
      bis_pkg::MODE_REMOVE: begin
        if (hit >= 0) begin
          slot_used[hit] = 1'b0;
          if (member_count > 0) member_count--;
          r.success = 1'b1;
        end
      end
      bis_pkg::MODE_QUERY: begin
        r.success = (hit >= 0);
      end
      default: begin
      end
    endcase
    r.set_size = member_count[bis_pkg::SIZE_W-1:0];
    pending_replies.push_back(r);
  endfunction

  function void check_reply(logic success, logic table_full,
                            logic [bis_pkg::SIZE_W-1:0] set_size);
    set_reply_t want;
    if (pending_replies.size() == 0) begin
      $error("result word with no prediction waiting");
      mismatches++;
      return;
    end
    want = pending_replies.pop_front();
    if (success !== want.success) begin
      $error("success: expected %0d, actual %0d", want.success, success);
      mismatches++;
    end
    if (table_full !== want.table_full) begin
      $error("table_full: expected %0d, actual %0d", want.table_full, table_full);
      mismatches++;
    end
    if (set_size !== want.set_size) begin
      $error("set_size: expected %0d, actual %0d", want.set_size, set_size);
      mismatches++;
    end
  endfunction
endclass

module bounded_integer_set_core_test;

  localparam int                         SLOTS       = bis_pkg::CAPACITY_DEF;
  localparam int                         POOL_SIZE   = 96;
  localparam int                         PHASE_WORDS = 560;
  localparam logic [bis_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic [bis_pkg::MODE_W-1:0]        in_mode;
  logic signed [bis_pkg::ELEM_W-1:0] in_element;
  logic                              out_valid;
  logic                              out_ready;
  logic                              out_success;
  logic                              out_table_full;
  logic [bis_pkg::SIZE_W-1:0]        out_set_size;

  int unsigned                send_idle_pct;
  int unsigned                recv_idle_pct;
  logic [bis_pkg::ELEM_W-1:0] value_pool [POOL_SIZE];
  set_shadow                  shadow;

  bounded_integer_set_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_element     (in_element),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_success    (out_success),
    .out_table_full (out_table_full),
    .out_set_size   (out_set_size)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      shadow.check_reply(out_success, out_table_full, out_set_size);
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_word(input logic [bis_pkg::MODE_W-1:0] mode,
                           input logic [bis_pkg::ELEM_W-1:0] elem);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_element <= elem;
    do @(posedge clk); while (!in_ready);
    shadow.note_request(mode, elem);
  endtask

  task automatic hold_until_settled();
    in_valid <= 1'b0;
    while (shadow.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [bis_pkg::ELEM_W-1:0] pick_element();
    if ($urandom_range(99) < 85) return value_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Bias 0 favors inserts, 1 favors removes and 2 spreads evenly.
  function automatic logic [bis_pkg::MODE_W-1:0] pick_mode(int bias);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return MODE_UNUSED;
    case (bias)
      0:       return (r < 75) ? bis_pkg::MODE_INSERT :
                      (r < 87) ? bis_pkg::MODE_REMOVE : bis_pkg::MODE_QUERY;
      1:       return (r < 70) ? bis_pkg::MODE_REMOVE :
                      (r < 82) ? bis_pkg::MODE_INSERT : bis_pkg::MODE_QUERY;
      default: return (r < 36) ? bis_pkg::MODE_INSERT :
                      (r < 68) ? bis_pkg::MODE_REMOVE : bis_pkg::MODE_QUERY;
    endcase
  endfunction

  // Each phase first fills the table and pushes four more inserts at it, so
  // that the full case is reached, then runs random bursts of mixed work.
  task automatic run_phase();
    int sent;
    int burst;
    int bias;
    int k;
    sent = 0;
    while (shadow.member_count < SLOTS) begin
      send_word(($urandom_range(99) < 90) ? bis_pkg::MODE_INSERT : bis_pkg::MODE_QUERY,
                pick_element());
      sent++;
    end
    for (k = 0; k < 4; k++) begin
      send_word(bis_pkg::MODE_INSERT, $urandom);
      sent++;
    end
    while (sent < PHASE_WORDS) begin
      burst = $urandom_range(80, 20);
      bias  = $urandom_range(2);
      for (k = 0; k < burst && sent < PHASE_WORDS; k++) begin
        send_word(pick_mode(bias), pick_element());
        sent++;
      end
    end
    hold_until_settled();
  endtask

  initial begin
    int i;
    shadow        = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mode       = bis_pkg::MODE_INSERT;
    in_element    = '0;
    out_ready     = 1'b0;
    send_idle_pct = 17;
    recv_idle_pct = 47;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_word(bis_pkg::MODE_QUERY,  32'h0000_0000);
    send_word(bis_pkg::MODE_REMOVE, 32'h0000_0000);
    send_word(bis_pkg::MODE_INSERT, 32'h8000_0000);
    send_word(bis_pkg::MODE_INSERT, 32'h7FFF_FFFF);
    send_word(bis_pkg::MODE_INSERT, 32'h0000_0000);
    send_word(bis_pkg::MODE_INSERT, 32'hFFFF_FFFF);
    send_word(bis_pkg::MODE_INSERT, 32'h8000_0000);
    send_word(bis_pkg::MODE_QUERY,  32'h7FFF_FFFF);
    send_word(bis_pkg::MODE_QUERY,  32'h7FFF_FFFE);
    send_word(bis_pkg::MODE_REMOVE, 32'h0000_0000);
    send_word(bis_pkg::MODE_REMOVE, 32'h0000_0000);
    send_word(bis_pkg::MODE_QUERY,  32'h0000_0000);
    send_word(MODE_UNUSED,          32'hFFFF_FFFF);
    send_word(MODE_UNUSED,          32'h0000_0000);
    send_word(bis_pkg::MODE_INSERT, 32'h5555_5555);
    send_word(bis_pkg::MODE_INSERT, 32'hAAAA_AAAA);
    send_word(bis_pkg::MODE_INSERT, 32'h0000_0000);
    send_word(bis_pkg::MODE_QUERY,  32'hAAAA_AAAA);
    send_word(bis_pkg::MODE_REMOVE, 32'h8000_0000);
    send_word(bis_pkg::MODE_REMOVE, 32'h7FFF_FFFF);
    send_word(bis_pkg::MODE_REMOVE, 32'hFFFF_FFFF);
    send_word(bis_pkg::MODE_REMOVE, 32'h5555_5555);
    send_word(bis_pkg::MODE_REMOVE, 32'hAAAA_AAAA);
    send_word(bis_pkg::MODE_REMOVE, 32'h0000_0000);
    hold_until_settled();

    run_phase();
    send_idle_pct = 47;
    recv_idle_pct = 17;
    run_phase();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase();

    repeat (SLOTS + 8) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(8 * 1000000);
    $display("tb: failure");
    $finish;
  end

endmodule
